[rtl/core/sstf_pkg.sv]
// ============================================================================
// sstf_pkg
// Shared types and constants for the shortest-seek-first request scheduler.
// ============================================================================
package sstf_pkg;

    // Fixed field widths of the channels
    localparam int IDX_W  = 6;
    localparam int CYL_W  = 16;
    localparam int TIME_W = 22;

    localparam logic [TIME_W-1:0] SEEK_MAX = {TIME_W{1'b1}};

    // Defaults for the top-level parameters
    localparam int DEF_MAX_REQUESTS  = 64;
    localparam int DEF_CYLINDER_BITS = 16;

    // Depth of the command queue between front and engine
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_START = 1'b1
    } t_cmd_kind;

    // Classified command; cylinder already masked to the configured width
    typedef struct packed {
        t_cmd_kind          kind;
        logic [CYL_W-1:0]   cyl;
    } t_cmd;

    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic [CYL_W-1:0]   cyl;
        logic [TIME_W-1:0]  done_time;
        logic               last;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

endpackage

[rtl/core/sstf_if.sv]
// ============================================================================
// sstf_if
// Valid/ready channels: request words in, served-request words out.
// ============================================================================
interface sstf_req_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [15:0] cylinder;

    modport source (output valid, output mode, output cylinder, input ready);
    modport sink   (input valid, input mode, input cylinder, output ready);
endinterface

interface sstf_res_if;
    logic        valid;
    logic        ready;
    logic [5:0]  request_index;
    logic [15:0] request_cylinder;
    logic [21:0] completion_time;
    logic        last;

    modport source (output valid, output request_index, output request_cylinder,
                    output completion_time, output last, input ready);
    modport sink   (input valid, input request_index, input request_cylinder,
                    input completion_time, input last, output ready);
endinterface

[rtl/core/sstf_front.sv]
// ============================================================================
// sstf_front
// Accepts request words, classifies and masks them, queues commands.
// ============================================================================
module sstf_front import sstf_pkg::*; #(
    parameter int CYLINDER_BITS = DEF_CYLINDER_BITS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    sstf_req_if.sink i_req,
    output logic    o_cmd_vld,
    output t_cmd    o_cmd,
    input  logic    i_cmd_pop
);
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CYL_W-1:0] CYL_MASK = (CYLINDER_BITS >= CYL_W) ? {CYL_W{1'b1}} :
                                            CYL_W'((32'd1 << CYLINDER_BITS) - 32'd1);

    t_cmd            r_q [QUEUE_DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [FW-1:0]   r_fill;
    logic            push, pop;
    t_cmd            cmd_in;

    assign i_req.ready = (r_fill != FW'(QUEUE_DEPTH));
    assign push        = i_req.valid && i_req.ready;
    assign pop         = i_cmd_pop && o_cmd_vld;
    assign o_cmd_vld   = (r_fill != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    always_comb begin
        cmd_in.kind = i_req.mode ? CMD_START : CMD_LOAD;
        cmd_in.cyl  = i_req.cylinder & CYL_MASK;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(QUEUE_DEPTH))
        else $error("command queue overfilled");

endmodule

[rtl/core/sstf_engine.sv]
// ============================================================================
// sstf_engine
// Request store and nearest-request scan; one result word per served request.
// ============================================================================
module sstf_engine import sstf_pkg::*; #(
    parameter int MAX_REQUESTS  = DEF_MAX_REQUESTS,
    parameter int CYLINDER_BITS = DEF_CYLINDER_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_vld,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    sstf_res_if.source o_res
);
    localparam int CB = CYLINDER_BITS;
    localparam int IW = $clog2(MAX_REQUESTS);
    localparam int CW = $clog2(MAX_REQUESTS + 1);
    localparam int SW = ((CB > TIME_W) ? CB : TIME_W) + 1;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_REQUESTS);

    // request store, read data registered
    logic [CB-1:0]           mem [MAX_REQUESTS];
    logic [CB-1:0]           r_rd_data;

    t_state                  r_state;
    logic [CW-1:0]           r_count, r_scan, r_picks;
    logic [MAX_REQUESTS-1:0] r_served;
    logic [CB-1:0]           r_head;
    logic [TIME_W-1:0]       r_elapsed;
    logic                    r_cmp_vld, r_found;
    logic [IW-1:0]           r_cmp_idx, r_best_idx;
    logic [CB-1:0]           r_best_dist, r_best_cyl;
    logic                    r_out_vld;
    t_result                 r_out;

    logic [CB+CYL_W-1:0]     cyl_wide;
    logic [CB-1:0]           cmd_cyl;
    logic                    load_we, start, issue, take, scan_done, out_free, push, push_last;
    logic [IW-1:0]           rd_addr;
    logic [CB-1:0]           cur_dist;
    logic [SW-1:0]           seek_sum;
    logic [TIME_W-1:0]       seek_sat;
    logic [IDX_W+IW-1:0]     idx_wide;
    logic [CYL_W+CB-1:0]     res_cyl_wide;

    assign cyl_wide  = {{CB{1'b0}}, i_cmd.cyl};
    assign cmd_cyl   = cyl_wide[CB-1:0];

    assign o_cmd_pop = (r_state == ST_IDLE) && i_cmd_vld;
    assign load_we   = o_cmd_pop && (i_cmd.kind == CMD_LOAD) && (r_count != CNT_MAX);
    assign start     = o_cmd_pop && (i_cmd.kind == CMD_START);

    assign issue     = (r_state == ST_SCAN) && (r_scan != r_count);
    assign rd_addr   = r_scan[IW-1:0];
    assign cur_dist  = (r_rd_data > r_head) ? r_rd_data - r_head : r_head - r_rd_data;
    assign take      = r_cmp_vld && !r_served[r_cmp_idx] &&
                       (!r_found || (cur_dist < r_best_dist));
    assign scan_done = (r_state == ST_SCAN) && (r_scan == r_count) && !r_cmp_vld;

    assign out_free  = !r_out_vld || o_res.ready;
    assign push      = (r_state == ST_EMIT) && out_free;
    assign push_last = (CW'(r_picks + 1'b1) == r_count);

    assign seek_sum  = SW'(r_elapsed) + SW'(r_best_dist);
    assign seek_sat  = (seek_sum > SW'(SEEK_MAX)) ? SEEK_MAX : seek_sum[TIME_W-1:0];

    assign idx_wide     = {{IDX_W{1'b0}}, r_best_idx};
    assign res_cyl_wide = {{CYL_W{1'b0}}, r_best_cyl};

    // store: written by loads, read once a cycle by the scan
    always_ff @(posedge i_clk) begin
        if (load_we) begin
            mem[r_count[IW-1:0]] <= cmd_cyl;
        end
        r_rd_data <= mem[rd_addr];
    end

    // scan datapath and result payload
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= rd_addr;
        if (take) begin
            r_best_idx  <= r_cmp_idx;
            r_best_dist <= cur_dist;
            r_best_cyl  <= r_rd_data;
        end
        if (push) begin
            r_out.idx       <= idx_wide[IDX_W-1:0];
            r_out.cyl       <= res_cyl_wide[CYL_W-1:0];
            r_out.done_time <= seek_sat;
            r_out.last      <= push_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_scan    <= '0;
            r_picks   <= '0;
            r_served  <= '0;
            r_head    <= '0;
            r_elapsed <= '0;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (push) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (load_we) begin
                        r_count <= r_count + 1'b1;
                    end
                    if (start) begin
                        r_head    <= cmd_cyl;
                        r_elapsed <= '0;
                        r_scan    <= '0;
                        r_picks   <= '0;
                        r_found   <= 1'b0;
                        r_cmp_vld <= 1'b0;
                        if (r_count != '0) begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    r_cmp_vld <= issue;
                    if (issue) begin
                        r_scan <= r_scan + 1'b1;
                    end
                    if (take) begin
                        r_found <= 1'b1;
                    end
                    if (scan_done) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (push) begin
                        r_elapsed <= seek_sat;
                        r_head    <= r_best_cyl;
                        r_picks   <= r_picks + 1'b1;
                        r_scan    <= '0;
                        r_found   <= 1'b0;
                        if (push_last) begin
                            r_count  <= '0;
                            r_served <= '0;
                            r_state  <= ST_IDLE;
                        end else begin
                            r_served[r_best_idx] <= 1'b1;
                            r_state <= ST_SCAN;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_res.valid            = r_out_vld;
    assign o_res.request_index    = r_out.idx;
    assign o_res.request_cylinder = r_out.cyl;
    assign o_res.completion_time  = r_out.done_time;
    assign o_res.last             = r_out.last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("request count past capacity");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan <= r_count)
        else $error("scan pointer past loaded requests");

    a_batch_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && push_last) |=> (r_count == '0) && (r_served == '0))
        else $error("batch not cleared after final result");

    a_emit_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> r_found)
        else $error("emit without a selected request");

    a_no_load_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_cmd_pop)
        else $error("command taken during a run");

endmodule

[rtl/core/sstf_disk_request_scheduler.sv]
// ============================================================================
// sstf_disk_request_scheduler
// Shortest-seek-first disk request scheduler, top level.
// ============================================================================
// Usage:
//   i_req carries command words: mode 0 loads one request cylinder into the
//   batch (dropped once MAX_REQUESTS are held), mode 1 gives the head cylinder
//   and serves the whole batch. o_res returns one word per served request:
//   its load index, cylinder, cumulative seek distance and a last flag.
//   Commands pass through a 4-word queue, so loads are taken one per cycle
//   while the engine is busy, until the queue fills.
// Operation:
//   A run over N requests makes N picks; each pick sweeps the loaded requests
//   through the store's single read port, and the engine takes no new command
//   until the run is over.
//   A start on an empty batch only sets the head and yields no word.
// Reset:
//   i_rst_n is synchronous, active low: batch empty, head and seek total zero,
//   queue and output register empty. The store itself is not cleared.
// Back-pressure:
//   The result sits in an output register; while o_res.ready is low the
//   engine holds the next pick, and the queue keeps taking commands until full.
// ============================================================================
module sstf_disk_request_scheduler import sstf_pkg::*; #(
    parameter int MAX_REQUESTS  = DEF_MAX_REQUESTS,
    parameter int CYLINDER_BITS = DEF_CYLINDER_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sstf_req_if.sink   i_req,
    sstf_res_if.source o_res
);
    // classified commands from front to engine
    logic cmd_vld;
    t_cmd cmd;
    logic cmd_pop;

    sstf_front #(
        .CYLINDER_BITS (CYLINDER_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_cmd_vld (cmd_vld),
        .o_cmd     (cmd),
        .i_cmd_pop (cmd_pop)
    );

    sstf_engine #(
        .MAX_REQUESTS  (MAX_REQUESTS),
        .CYLINDER_BITS (CYLINDER_BITS)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_vld (cmd_vld),
        .i_cmd     (cmd),
        .o_cmd_pop (cmd_pop),
        .o_res     (o_res)
    );

endmodule
